[src/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define LPR_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lpr_pkg.sv]
// types, codes and helpers of the longest prefix router
// no dependencies
`default_nettype none

package lpr_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam logic [5:0]  MAX_LEN = 6'd32;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_FORWARDED = 3'd2,
    ST_DROP_TTL  = 3'd3,
    ST_NO_ROUTE  = 3'd4
  } lpr_status_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] add_prefix;
    logic [5:0]        add_length;
    logic              has_next_hop;
    logic [ADDR_W-1:0] next_hop_in;
    logic [1:0]        interface_index;
    logic [ADDR_W-1:0] dst_address;
    logic [7:0]        ttl_in;
  } lpr_in_t;

  typedef struct packed {
    lpr_status_t       status;
    logic [1:0]        egress_interface;
    logic [ADDR_W-1:0] forward_address;
    logic [7:0]        ttl_out;
  } lpr_out_t;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [5:0]        length;
    logic              hop_valid;
    logic [ADDR_W-1:0] hop;
    logic [1:0]        iface;
  } lpr_entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } lpr_mem_ctl_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
  } lpr_match_ctl_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        iface;
    logic [ADDR_W-1:0] fwd;
  } lpr_match_t;

  // top len bits set; a shift by 32 clears the word, so len 32 gives all ones
  function automatic logic [ADDR_W-1:0] len_mask(input logic [5:0] len);
    len_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

`default_nettype wire

[src/lpr_table.sv]
// route table memory: one write port, one registered read port
// depends on lpr_pkg
`default_nettype none

module lpr_table #(
  parameter int MAX_ROUTES = 64
) (
  input  wire                          clk,
  input  wire lpr_pkg::lpr_mem_ctl_t   ctl,
  input  wire [$clog2(MAX_ROUTES)-1:0] wr_addr,
  input  wire lpr_pkg::lpr_entry_t     wr_data,
  input  wire [$clog2(MAX_ROUTES)-1:0] rd_addr,
  output lpr_pkg::lpr_entry_t          rd_data
);

  lpr_pkg::lpr_entry_t mem [MAX_ROUTES];
  lpr_pkg::lpr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/lpr_match.sv]
// best-match tracker: compares each entry read from the table against the
// destination and keeps the longest hit; depends on lpr_pkg
`default_nettype none

module lpr_match (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lpr_pkg::lpr_match_ctl_t ctl,
  input  wire [lpr_pkg::ADDR_W-1:0]    dst,
  input  wire lpr_pkg::lpr_entry_t     entry,
  output lpr_pkg::lpr_match_t          best
);

  logic                       found_r, found_nxt;
  logic [5:0]                 best_len_r;
  logic [1:0]                 iface_r;
  logic [lpr_pkg::ADDR_W-1:0] fwd_r;
  logic                       hit;
  logic                       take;

  assign hit  = ((dst ^ entry.prefix) & lpr_pkg::len_mask(entry.length)) == '0;
  // strict compare keeps the earlier entry on equal lengths
  assign take = ctl.cmp_en && hit && (!found_r || (entry.length > best_len_r));

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_len_r <= entry.length;
      iface_r    <= entry.iface;
      fwd_r      <= entry.hop_valid ? entry.hop : dst;
    end
  end

  assign best.found = found_r;
  assign best.iface = iface_r;
  assign best.fwd   = fwd_r;

endmodule

`default_nettype wire

[src/ipv4_longest_prefix_router_unit.sv]
// top level of the ipv4 longest prefix router: control sequencer, entry
// count and output register; depends on lpr_pkg, lpr_table, lpr_match
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------
//   input   | in_valid / in_ready | in_data  (lpr_in_t)
//   output  | out_valid/out_ready | out_data (lpr_out_t)
//
// add and TTL-drop items: accept, then the finish state loads the result.
// lookups: accept, scan, finish; the scan reads one entry per cycle from the
// single read port of the table memory.
// one item is in work at a time; in_ready rises as the result is loaded and stays
// high while it waits; a stalled full output register holds the sequencer back.
// rst_n clears the entry count and control state; table contents are kept.
`default_nettype none

module ipv4_longest_prefix_router_unit #(
  parameter int MAX_ROUTES = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire lpr_pkg::lpr_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output lpr_pkg::lpr_out_t      out_data
);

  localparam int IDX_W = $clog2(MAX_ROUTES);
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           issue_r, issue_nxt;
  logic                       dv_r, dv_nxt;
  logic [lpr_pkg::ADDR_W-1:0] dst_r, dst_nxt;
  logic [7:0]                 ttl_r, ttl_nxt;
  lpr_pkg::lpr_status_t       status_r, status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lpr_pkg::lpr_out_t          out_data_r, out_data_nxt;

  logic                       acc;
  logic                       full;
  logic                       issuing;
  lpr_pkg::lpr_mem_ctl_t      mem_ctl;
  lpr_pkg::lpr_match_ctl_t    match_ctl;
  lpr_pkg::lpr_entry_t        wr_entry;
  lpr_pkg::lpr_entry_t        rd_entry;
  lpr_pkg::lpr_match_t        best;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(MAX_ROUTES));
  assign issuing  = (issue_r < count_r);

  always_comb begin
    wr_entry.prefix    = in_data.add_prefix;
    wr_entry.length    = (in_data.add_length > lpr_pkg::MAX_LEN) ?
                         lpr_pkg::MAX_LEN : in_data.add_length;
    wr_entry.hop_valid = in_data.has_next_hop;
    wr_entry.hop       = in_data.next_hop_in;
    wr_entry.iface     = in_data.interface_index;
  end

  assign mem_ctl.wr_en = acc && !in_data.cmd && !full;
  assign mem_ctl.rd_en = (state_r == S_SCAN) && issuing;

  assign match_ctl.clear  = acc;
  assign match_ctl.cmp_en = (state_r == S_SCAN) && dv_r;

  lpr_table #(
    .MAX_ROUTES(MAX_ROUTES)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  lpr_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (match_ctl),
    .dst   (dst_r),
    .entry (rd_entry),
    .best  (best)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    dv_nxt        = 1'b0;
    dst_nxt       = dst_r;
    ttl_nxt       = ttl_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          dst_nxt   = in_data.dst_address;
          ttl_nxt   = in_data.ttl_in;
          issue_nxt = '0;
          if (!in_data.cmd) begin
            state_nxt = S_FIN;
            if (full) begin
              status_nxt = lpr_pkg::ST_FULL;
            end else begin
              status_nxt = lpr_pkg::ST_ADDED;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (in_data.ttl_in <= 8'd1) begin
            state_nxt  = S_FIN;
            status_nxt = lpr_pkg::ST_DROP_TTL;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read at issue_r now, compare that entry next cycle
        if (issuing) begin
          issue_nxt = issue_r + CNT_W'(1);
          dv_nxt    = 1'b1;
        end else if (!dv_r) begin
          state_nxt  = S_FIN;
          status_nxt = best.found ? lpr_pkg::ST_FORWARDED : lpr_pkg::ST_NO_ROUTE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = status_r;
          if (status_r == lpr_pkg::ST_FORWARDED) begin
            out_data_nxt.egress_interface = best.iface;
            out_data_nxt.forward_address  = best.fwd;
            out_data_nxt.ttl_out          = ttl_r - 8'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    ttl_r      <= ttl_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/lpr_checker.sv]
// port-level checks of the router top level, bound to it below
// depends on lpr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module lpr_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire lpr_pkg::lpr_out_t out_data
);

  logic stall;
  logic is_fwd;
  logic rest_zero;
  logic ttl_ok;

  assign stall     = out_valid && !out_ready;
  assign is_fwd    = (out_data.status == lpr_pkg::ST_FORWARDED);
  assign rest_zero = (out_data.egress_interface == '0) &&
                     (out_data.forward_address == '0) && (out_data.ttl_out == '0);
  assign ttl_ok    = (out_data.ttl_out != 8'hFF) && (out_data.ttl_out != 8'h00);

  `LPR_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid, "out_valid after reset")

  `LPR_ASSERT_ON(a_out_hold, clk, rst_n, stall |=> out_valid, "out item dropped")

  `LPR_ASSERT_ON(a_out_stable, clk, rst_n, stall |=> $stable(out_data), "out item changed")

  `LPR_ASSERT_ON(a_zero_fields, clk, rst_n, out_valid && !is_fwd |-> rest_zero, "fields set")

  `LPR_ASSERT_ON(a_ttl_dec, clk, rst_n, out_valid && is_fwd |-> ttl_ok, "forwarded bad ttl")

endmodule

bind ipv4_longest_prefix_router_unit lpr_checker u_lpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
